### hw/rtl/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// shared types, operation and status codes for the indexed list engine
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int GROUP_SIZE     = 8;
	localparam int GROUP_W        = 3;

	localparam logic [3:0] K_ADD_AT       = 4'd0;
	localparam logic [3:0] K_ADD_HEAD     = 4'd1;
	localparam logic [3:0] K_ADD_TAIL     = 4'd2;
	localparam logic [3:0] K_EXTRACT_AT   = 4'd3;
	localparam logic [3:0] K_EXTRACT_HEAD = 4'd4;
	localparam logic [3:0] K_EXTRACT_TAIL = 4'd5;
	localparam logic [3:0] K_GET          = 4'd6;
	localparam logic [3:0] K_SET          = 4'd7;
	localparam logic [3:0] K_INDEX_OF     = 4'd8;
	localparam logic [3:0] K_SWAP         = 4'd9;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [3:0]         kind;
		logic [6:0]         index;
		logic [6:0]         second_index;
		logic signed [31:0] element;
	} ile_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic [5:0]         found_index;
		logic [6:0]         length;
	} ile_rsp_t;

	typedef struct packed {
		logic insert;
		logic remove;
		logic we_a;
		logic we_b;
	} ile_cell_ctl_t;

endpackage

### hw/rtl/ile_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell
// one list slot: shifts with its neighbours, takes direct writes, compares
// ----------------------------------------------------------------------------
module ile_cell
	import ile_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CW         = 7,
	parameter int MY_POS     = 0
) (
	input  logic                  clk,
	input  ile_cell_ctl_t         ctl,
	input  logic [CW-1:0]         pos_a,
	input  logic [CW-1:0]         pos_b,
	input  logic [CW-1:0]         len,
	input  logic [DATA_WIDTH-1:0] word_a,
	input  logic [DATA_WIDTH-1:0] word_b,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [DATA_WIDTH-1:0] from_lo,
	input  logic [DATA_WIDTH-1:0] from_hi,
	output logic [DATA_WIDTH-1:0] q,
	output logic                  sel_a,
	output logic                  sel_b,
	output logic                  match
);

	localparam logic [CW-1:0] MY = CW'(MY_POS);

	logic [DATA_WIDTH-1:0] slot_q;
	logic                  above_a;

	assign sel_a   = (MY == pos_a);
	assign sel_b   = (MY == pos_b);
	assign above_a = (MY > pos_a);
	assign match   = (MY < len) && (slot_q == key);
	assign q       = slot_q;

	always_ff @(posedge clk) begin
		priority if (ctl.insert) begin
			if (sel_a) begin
				slot_q <= word_a;
			end else if (above_a) begin
				slot_q <= from_lo;
			end
		end else if (ctl.remove) begin
			if (sel_a || above_a) begin
				slot_q <= from_hi;
			end
		end else if (ctl.we_a && sel_a) begin
			slot_q <= word_a;
		end else if (ctl.we_b && sel_b) begin
			slot_q <= word_b;
		end
	end

endmodule

### hw/rtl/ile_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_reduce
// two-level registered tree: selected words and first match over the cells
// ----------------------------------------------------------------------------
module ile_reduce
	import ile_pkg::*;
#(
	parameter int N          = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic [DATA_WIDTH-1:0]        word [N],
	input  logic [N-1:0]                 sel_a,
	input  logic [N-1:0]                 sel_b,
	input  logic [N-1:0]                 match,
	output logic [DATA_WIDTH-1:0]        rd_a_s2,
	output logic [DATA_WIDTH-1:0]        rd_b_s2,
	output logic                         hit_s2,
	output logic [$clog2(N)-1:0]         found_s2
);

	localparam int NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int IW = $clog2(N);

	logic [DATA_WIDTH-1:0] ga_c [NG];
	logic [DATA_WIDTH-1:0] gb_c [NG];
	logic [NG-1:0]         gh_c;
	logic [GROUP_W-1:0]    gf_c [NG];

	logic [DATA_WIDTH-1:0] ga_s1 [NG];
	logic [DATA_WIDTH-1:0] gb_s1 [NG];
	logic [NG-1:0]         gh_s1;
	logic [GROUP_W-1:0]    gf_s1 [NG];

	logic [DATA_WIDTH-1:0] rd_a_c;
	logic [DATA_WIDTH-1:0] rd_b_c;
	logic                  hit_c;
	logic [IW-1:0]         found_c;

	// first level: inside each group of cells
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			ga_c[g] = '0;
			gb_c[g] = '0;
			gh_c[g] = 1'b0;
			gf_c[g] = '0;
			for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
				if (g * GROUP_SIZE + j < N) begin
					if (sel_a[g * GROUP_SIZE + j]) begin
						ga_c[g] = ga_c[g] | word[g * GROUP_SIZE + j];
					end
					if (sel_b[g * GROUP_SIZE + j]) begin
						gb_c[g] = gb_c[g] | word[g * GROUP_SIZE + j];
					end
					if (match[g * GROUP_SIZE + j]) begin
						gh_c[g] = 1'b1;
						gf_c[g] = GROUP_W'(j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ga_s1 <= ga_c;
		gb_s1 <= gb_c;
		gh_s1 <= gh_c;
		gf_s1 <= gf_c;
	end

	// second level: across groups, lowest group wins the search
	always_comb begin
		rd_a_c  = '0;
		rd_b_c  = '0;
		hit_c   = 1'b0;
		found_c = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			rd_a_c = rd_a_c | ga_s1[g];
			rd_b_c = rd_b_c | gb_s1[g];
			if (gh_s1[g]) begin
				hit_c   = 1'b1;
				found_c = IW'(g * GROUP_SIZE + int'(gf_s1[g]));
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s2  <= rd_a_c;
		rd_b_s2  <= rd_b_c;
		hit_s2   <= hit_c;
		found_s2 <= found_c;
	end

endmodule

### hw/rtl/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// bounded ordered list of signed words kept in a row of slot cells
// ----------------------------------------------------------------------------
// The command is latched at the accepting edge and then passes through the
// gather and reduce states, in which the two registered levels of the group
// tree read the addressed slots and find the first match, and the apply state,
// in which every cell shifts or writes at once while the result is registered;
// the done beat follows apply. busy is high in the gather, reduce and apply
// states; a new command can be taken in the cycle that carries done.
// The result beat is valid for one cycle only and must be captured then.
// Slots hold no reset value; only positions below the length are ever read.
module indexed_list_engine_unit
	import ile_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ile_req_t request,
	output logic     done,
	output ile_rsp_t result
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = (PW > 7) ? PW : 7;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_GATHER = 4'b0010,
		S_REDUCE = 4'b0100,
		S_APPLY  = 4'b1000
	} state_t;

	state_t          state_q;
	ile_req_t        req_q;
	logic [PW-1:0]   len_q;
	logic            done_q;
	ile_rsp_t        result_q;

	logic [CW-1:0]         idx_w;
	logic [CW-1:0]         idx2_w;
	logic [CW-1:0]         len_w;
	logic [CW-1:0]         pos_c;
	logic [DATA_WIDTH-1:0] elem_w;

	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [CAPACITY-1:0]   sel_a;
	logic [CAPACITY-1:0]   sel_b;
	logic [CAPACITY-1:0]   match;

	logic [DATA_WIDTH-1:0] rd_a_s2;
	logic [DATA_WIDTH-1:0] rd_b_s2;
	logic                  hit_s2;
	logic [IW-1:0]         found_s2;

	logic [2:0]            status_c;
	logic [DATA_WIDTH-1:0] value_c;
	logic [IW-1:0]         found_c;
	logic [PW-1:0]         len_nx;
	ile_cell_ctl_t         ctl_c;
	ile_cell_ctl_t         ctl_apply;
	logic [DATA_WIDTH-1:0] word_a_c;
	logic [DATA_WIDTH-1:0] word_b_c;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign idx_w  = CW'(req_q.index);
	assign idx2_w = CW'(req_q.second_index);
	assign len_w  = CW'(len_q);
	assign elem_w = DATA_WIDTH'(req_q.element);

	always_comb begin
		unique case (req_q.kind)
			K_ADD_HEAD, K_EXTRACT_HEAD: pos_c = '0;
			K_ADD_TAIL:                 pos_c = len_w;
			K_EXTRACT_TAIL:             pos_c = len_w - CW'(1);
			default:                    pos_c = idx_w;
		endcase
	end

	// decode of the latched command against the tree results
	always_comb begin
		status_c = ST_OK;
		value_c  = '0;
		found_c  = '0;
		len_nx   = len_q;
		ctl_c    = '0;
		word_a_c = elem_w;
		word_b_c = rd_a_s2;
		unique case (req_q.kind)
			K_ADD_AT, K_ADD_HEAD, K_ADD_TAIL: begin
				if (pos_c > len_w) begin
					status_c = ST_BAD_INDEX;
				end else if (len_w >= CW'(CAPACITY)) begin
					status_c = ST_FULL;
				end else begin
					ctl_c.insert = 1'b1;
					len_nx       = len_q + PW'(1);
				end
			end
			K_EXTRACT_AT, K_EXTRACT_HEAD, K_EXTRACT_TAIL: begin
				if (req_q.kind != K_EXTRACT_AT && len_q == '0) begin
					status_c = ST_EMPTY;
				end else if (pos_c >= len_w) begin
					status_c = ST_BAD_INDEX;
				end else begin
					value_c      = rd_a_s2;
					ctl_c.remove = 1'b1;
					len_nx       = len_q - PW'(1);
				end
			end
			K_GET: begin
				if (idx_w >= len_w) begin
					status_c = ST_BAD_INDEX;
				end else begin
					value_c = rd_a_s2;
				end
			end
			K_SET: begin
				if (idx_w >= len_w) begin
					status_c = ST_BAD_INDEX;
				end else begin
					ctl_c.we_a = 1'b1;
				end
			end
			K_INDEX_OF: begin
				if (hit_s2) begin
					found_c = found_s2;
				end else begin
					status_c = ST_NOT_FOUND;
				end
			end
			K_SWAP: begin
				if (idx_w >= len_w || idx2_w >= len_w) begin
					status_c = ST_BAD_INDEX;
				end else begin
					ctl_c.we_a = 1'b1;
					ctl_c.we_b = 1'b1;
					word_a_c   = rd_b_s2;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl_apply = (state_q == S_APPLY) ? ctl_c : '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lo_w;
		logic [DATA_WIDTH-1:0] hi_w;

		if (i == 0) begin : g_first
			assign lo_w = word_a_c;
		end else begin : g_mid_lo
			assign lo_w = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign hi_w = cell_q[i];
		end else begin : g_mid_hi
			assign hi_w = cell_q[i+1];
		end

		ile_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CW         (CW),
			.MY_POS     (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl_apply),
			.pos_a   (pos_c),
			.pos_b   (idx2_w),
			.len     (len_w),
			.word_a  (word_a_c),
			.word_b  (word_b_c),
			.key     (elem_w),
			.from_lo (lo_w),
			.from_hi (hi_w),
			.q       (cell_q[i]),
			.sel_a   (sel_a[i]),
			.sel_b   (sel_b[i]),
			.match   (match[i])
		);
	end

	ile_reduce #(
		.N          (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_reduce (
		.clk      (clk),
		.word     (cell_q),
		.sel_a    (sel_a),
		.sel_b    (sel_b),
		.match    (match),
		.rd_a_s2  (rd_a_s2),
		.rd_b_s2  (rd_b_s2),
		.hit_s2   (hit_s2),
		.found_s2 (found_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_APPLY);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_GATHER;
					end
				end
				S_GATHER: state_q <= S_REDUCE;
				S_REDUCE: state_q <= S_APPLY;
				S_APPLY: begin
					len_q   <= len_nx;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		if (state_q == S_APPLY) begin
			result_q.status      <= status_c;
			result_q.value       <= 32'(value_c);
			result_q.found_index <= 6'(found_c);
			result_q.length      <= 7'(len_nx);
		end
	end

	a_done_after_apply : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_APPLY))
		else $error("done beat without an apply cycle");

	a_accept_starts : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_GATHER))
		else $error("accepted beat did not start the sequence");

	a_len_bound : assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PW'(CAPACITY))
		else $error("length beyond capacity");

	a_len_moves_in_apply : assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(len_q) |-> $past(state_q == S_APPLY))
		else $error("length changed outside apply");

	a_error_has_no_value : assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status != ST_OK) |-> (result_q.value == '0))
		else $error("failed beat carries a value");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for indexed_list_engine_unit: commands are driven on the
// start/busy handshake and every done beat is compared, field by field, with
// the result computed by a behavioural list model kept inside the bench
// ----------------------------------------------------------------------------
module tb;
	import ile_pkg::*;

	localparam int CAP         = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 10;

	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIX    = 2;

	logic     clk;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	ile_req_t request = '0;
	logic     busy;
	logic     done;
	ile_rsp_t result;

	logic [31:0] list_slots [CAP];
	int          list_len   = 0;
	ile_rsp_t    pending_rsp [$];
	int          err_count  = 0;
	int          cycles     = 0;
	bit          no_gaps    = 1'b0;

	indexed_list_engine_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// list model

	function automatic logic [2:0] list_insert(int pos, logic [31:0] word);
		if (pos > list_len)
			return ST_BAD_INDEX;
		if (list_len >= CAP)
			return ST_FULL;
		for (int i = list_len; i > pos; i--)
			list_slots[i] = list_slots[i - 1];
		list_slots[pos] = word;
		list_len++;
		return ST_OK;
	endfunction

	function automatic logic [2:0] list_remove(int pos, output logic [31:0] word);
		word = '0;
		if (pos >= list_len)
			return ST_BAD_INDEX;
		word = list_slots[pos];
		for (int i = pos; i + 1 < list_len; i++)
			list_slots[i] = list_slots[i + 1];
		list_len--;
		return ST_OK;
	endfunction

	function automatic ile_rsp_t apply_list_op(ile_req_t r);
		ile_rsp_t    o;
		logic [31:0] word;
		logic [31:0] tmp;
		int          a;
		int          b;
		o        = '0;
		o.status = ST_OK;
		word     = '0;
		a        = int'(r.index);
		b        = int'(r.second_index);
		case (r.kind)
			K_ADD_AT:       o.status = list_insert(a, r.element);
			K_ADD_HEAD:     o.status = list_insert(0, r.element);
			K_ADD_TAIL:     o.status = list_insert(list_len, r.element);
			K_EXTRACT_AT:   o.status = list_remove(a, word);
			K_EXTRACT_HEAD: begin
				if (list_len == 0)
					o.status = ST_EMPTY;
				else
					o.status = list_remove(0, word);
			end
			K_EXTRACT_TAIL: begin
				if (list_len == 0)
					o.status = ST_EMPTY;
				else
					o.status = list_remove(list_len - 1, word);
			end
			K_GET: begin
				if (a >= list_len)
					o.status = ST_BAD_INDEX;
				else
					word = list_slots[a];
			end
			K_SET: begin
				if (a >= list_len)
					o.status = ST_BAD_INDEX;
				else
					list_slots[a] = r.element;
			end
			K_INDEX_OF: begin
				o.status = ST_NOT_FOUND;
				for (int i = 0; i < list_len; i++) begin
					if (list_slots[i] == r.element) begin
						o.status      = ST_OK;
						o.found_index = i[5:0];
						break;
					end
				end
			end
			K_SWAP: begin
				if (a >= list_len || b >= list_len) begin
					o.status = ST_BAD_INDEX;
				end else if (a != b) begin
					tmp           = list_slots[a];
					list_slots[a] = list_slots[b];
					list_slots[b] = tmp;
				end
			end
			default: ;
		endcase
		o.value  = (o.status == ST_OK) ? word : '0;
		o.length = list_len[6:0];
		return o;
	endfunction

	// result checking

	always @(posedge clk) begin
		ile_rsp_t want;
		if (done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected done beat: status %0d value %0d", $time,
					result.status, result.value);
				err_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (result.status !== want.status) begin
					$display("%0t status: expected %0d actual %0d", $time,
						want.status, result.status);
					err_count++;
				end
				if (result.value !== want.value) begin
					$display("%0t value: expected %0d actual %0d", $time,
						want.value, result.value);
					err_count++;
				end
				if (result.found_index !== want.found_index) begin
					$display("%0t found_index: expected %0d actual %0d", $time,
						want.found_index, result.found_index);
					err_count++;
				end
				if (result.length !== want.length) begin
					$display("%0t length: expected %0d actual %0d", $time,
						want.length, result.length);
					err_count++;
				end
			end
		end
	end

	// stimulus helpers

	function automatic ile_req_t mk(logic [3:0] k, int a, int b, logic [31:0] e);
		ile_req_t r;
		r.kind         = k;
		r.index        = a[6:0];
		r.second_index = b[6:0];
		r.element      = e;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_gaps || p < 40)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic int pick_pos(bit access);
		int q;
		int upper;
		q     = $urandom_range(0, 9);
		upper = (access && list_len > 0) ? list_len - 1 : list_len;
		if (q < 7)
			return $urandom_range(0, upper);
		if (q == 7)
			return $urandom_range(0, 127);
		if (q == 8)
			return list_len;
		return $urandom_range(64, 127);
	endfunction

	function automatic logic [31:0] pick_element();
		int e;
		e = $urandom_range(0, 9);
		if (e < 4)
			return $urandom;
		if (e < 7)
			return $urandom_range(0, 7);
		if (e == 7 && list_len > 0)
			return list_slots[$urandom_range(0, list_len - 1)];
		if (e == 9)
			return -$urandom_range(1, 8);
		case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			default: return 32'h0000_0000;
		endcase
	endfunction

	function automatic ile_req_t make_op(int mode);
		ile_req_t r;
		int       p;
		int       add_w;
		int       rem_w;
		add_w = (mode == MODE_GROW) ? 60 : (mode == MODE_SHRINK) ? 10 : 30;
		rem_w = (mode == MODE_GROW) ? 12 : (mode == MODE_SHRINK) ? 55 : 25;
		p     = $urandom_range(0, 99);
		if (p < 3)
			r.kind = 4'($urandom_range(10, 15));
		else if (p < 3 + add_w)
			r.kind = 4'($urandom_range(0, 2));
		else if (p < 3 + add_w + rem_w)
			r.kind = 4'($urandom_range(3, 5));
		else
			r.kind = 4'($urandom_range(6, 9));
		r.index        = 7'(pick_pos(r.kind != K_ADD_AT));
		r.second_index = 7'(pick_pos(1'b1));
		r.element      = pick_element();
		return r;
	endfunction

	// drive one command beat and hold it until the block takes it
	task automatic issue_cmd(ile_req_t r);
		int g;
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_rsp.push_back(apply_list_op(r));
		g = pick_gap();
		if (g > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (g - 1)
				@(negedge clk);
		end
	endtask

	task automatic wait_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// tests

	task automatic test_empty_list();
		issue_cmd(mk(K_EXTRACT_HEAD, 0, 0, 0));
		issue_cmd(mk(K_EXTRACT_TAIL, 0, 0, 0));
		issue_cmd(mk(K_EXTRACT_AT, 0, 0, 0));
		issue_cmd(mk(K_GET, 0, 0, 0));
		issue_cmd(mk(K_SET, 0, 0, 32'h1234_5678));
		issue_cmd(mk(K_SWAP, 0, 0, 0));
		issue_cmd(mk(K_INDEX_OF, 0, 0, 0));
		issue_cmd(mk(K_ADD_AT, 1, 0, 7));
		issue_cmd(mk(4'd10, 127, 127, 32'hffff_ffff));
		issue_cmd(mk(4'd15, 0, 0, 0));
	endtask

	task automatic test_edge_values();
		issue_cmd(mk(K_ADD_HEAD, 0, 0, 32'h8000_0000));
		issue_cmd(mk(K_ADD_TAIL, 0, 0, 32'h7fff_ffff));
		issue_cmd(mk(K_ADD_AT, 1, 0, 32'hffff_ffff));
		issue_cmd(mk(K_ADD_AT, 0, 0, 32'h0));
		issue_cmd(mk(K_GET, 3, 0, 0));
		issue_cmd(mk(K_SET, 2, 0, 32'd5));
		issue_cmd(mk(K_INDEX_OF, 0, 0, 32'h7fff_ffff));
		issue_cmd(mk(K_INDEX_OF, 0, 0, 32'd5));
		issue_cmd(mk(K_INDEX_OF, 0, 0, 32'd99));
		issue_cmd(mk(K_SWAP, 0, 3, 0));
		issue_cmd(mk(K_SWAP, 1, 1, 0));
		issue_cmd(mk(K_SWAP, 0, 4, 0));
		issue_cmd(mk(K_GET, 64, 0, 0));
		issue_cmd(mk(K_EXTRACT_AT, 127, 0, 0));
		issue_cmd(mk(K_EXTRACT_AT, 1, 0, 0));
		issue_cmd(mk(K_EXTRACT_HEAD, 0, 0, 0));
		issue_cmd(mk(K_EXTRACT_TAIL, 0, 0, 0));
	endtask

	task automatic test_random(int mode, int n);
		for (int i = 0; i < n; i++)
			issue_cmd(make_op(mode));
	endtask

	// back to back beats with no idle cycles from the sender
	task automatic test_burst(int n);
		no_gaps = 1'b1;
		test_random(MODE_MIX, n);
		no_gaps = 1'b0;
	endtask

	task automatic test_pause_for_results();
		test_random(MODE_MIX, 10);
		wait_results();
		test_random(MODE_MIX, 10);
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_values();
		test_random(MODE_GROW, 200);
		test_burst(80);
		test_pause_for_results();
		test_random(MODE_SHRINK, 120);
		test_random(MODE_MIX, 80);

		wait_results();
		repeat (DRAIN_WAIT)
			@(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
